// ----- design/ssca_pkg.sv -----
// package: constants, codes and lookup functions of the slab size-class allocator
`default_nettype none
package ssca_pkg;

    localparam int SPAN_BYTES      = 16384;
    localparam int ARENA_BYTES     = 1048576;
    localparam int HEADER_BYTES    = 64;
    localparam int NUM_CLASSES     = 16;
    localparam int MAX_SMALL_BYTES = 4096;

    localparam int AW         = $clog2(ARENA_BYTES);
    localparam int EW         = AW + 1;
    localparam int SLOT_W     = AW - 4;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int SLOT_COUNT = ARENA_BYTES >> 4;
    localparam int SPAN_SH    = $clog2(SPAN_BYTES);
    localparam int SPAN_COUNT = ARENA_BYTES / SPAN_BYTES;
    localparam int SPAN_IW    = (SPAN_COUNT > 1) ? $clog2(SPAN_COUNT) : 1;
    localparam int SU_W       = $clog2(SPAN_COUNT + 1);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FALLBACK = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNTAGGED = 3'd3,
        ST_FREED    = 3'd4
    } t_status;

    function automatic logic [EW-1:0] obj_size(input logic [3:0] c);
        logic [12:0] s;
        unique case (c)
            4'd0:  s = 13'd16;
            4'd1:  s = 13'd32;
            4'd2:  s = 13'd48;
            4'd3:  s = 13'd64;
            4'd4:  s = 13'd96;
            4'd5:  s = 13'd128;
            4'd6:  s = 13'd192;
            4'd7:  s = 13'd256;
            4'd8:  s = 13'd384;
            4'd9:  s = 13'd512;
            4'd10: s = 13'd768;
            4'd11: s = 13'd1024;
            4'd12: s = 13'd1536;
            4'd13: s = 13'd2048;
            4'd14: s = 13'd3072;
            default: s = 13'd4096;
        endcase
        return EW'(s);
    endfunction

    // bit 4 set means no class
    function automatic logic [4:0] class_of(input logic [15:0] size);
        logic [4:0] c;
        logic       found;
        c     = 5'd16;
        found = 1'b0;
        if (size <= 16'(MAX_SMALL_BYTES)) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                if (!found && ({4'd0, size} <= 20'(obj_size(4'(i))))) begin
                    c     = 5'(i);
                    found = 1'b1;
                end
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/ssca_if.sv -----
// interfaces: request, response and configuration channels
`default_nettype none
interface ssca_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_size;
    logic [23:0] address;
    modport source (output valid, command, request_size, address, input ready);
    modport sink   (input valid, command, request_size, address, output ready);
endinterface

interface ssca_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] address_out;
    logic [3:0]  size_class;
    logic [2:0]  status;
    modport source (output valid, address_out, size_class, status, input ready);
    modport sink   (input valid, address_out, size_class, status, output ready);
endinterface

interface ssca_cfg_if;
    logic valid;
    logic ready;
    logic shard_bound;
    modport source (output valid, shard_bound, input ready);
    modport sink   (input valid, shard_bound, output ready);
endinterface
`default_nettype wire

// ----- design/slab_size_class_allocator.sv -----
// top level: slab allocator with segregated free lists over one arena
// An allocate or free request is taken when the block is idle and its
// response is registered; the next request is taken once that response
// has been delivered. A pop from a free list reads the class head and then the
// link memory before it responds, a free reads the span tag memory and then
// writes the link, and fallback and untagged-free cases respond from idle.
// An allocate that finds its list empty formats a new span: one shared
// adder steps through the objects and the link memory takes one write per
// cycle. There is no clearing pass after reset.
`default_nettype none
module slab_size_class_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssca_cfg_if.sink   i_cfg,
    ssca_req_if.sink   i_req,
    ssca_rsp_if.source o_rsp
);
    import ssca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ALOC, S_POP, S_FMT0, S_FMT, S_FREE
    } t_state;

    t_state r_state;
    logic   r_bound;
    logic [LINK_W-1:0] r_heads [NUM_CLASSES];
    logic [SU_W-1:0]   r_spans_used;
    logic [3:0]        r_cls;
    logic [EW-1:0]     r_cur, r_end, r_first, r_osz;
    logic [LINK_W-1:0] r_prev;
    logic [SLOT_W-1:0] r_slot;

    logic          r_out_valid;
    logic [19:0]   r_out_addr;
    logic [3:0]    r_out_cls;
    t_status       r_out_st;

    logic [LINK_W-1:0] link_mem [SLOT_COUNT];
    logic [LINK_W-1:0] r_link_q;
    logic [3:0]        span_mem [SPAN_COUNT];
    logic [3:0]        r_tag_q;

    logic              acc;
    logic [4:0]        cls_in;
    logic              foreign;
    logic [SPAN_IW-1:0] span_in;
    logic              span_tagged;
    logic [EW-1:0]     sum;
    logic              fits;
    logic [LINK_W-1:0] cur_link;
    logic [LINK_W-1:0] head_c;
    logic              full;
    logic [EW-1:0]     base;
    logic              link_we;
    logic [SLOT_W-1:0] link_wa, link_ra;
    logic [LINK_W-1:0] link_wd;
    logic              span_we;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.address_out = r_out_addr;
    assign o_rsp.size_class = r_out_cls;
    assign o_rsp.status = r_out_st;

    always_comb begin
        acc         = i_req.valid && i_req.ready;
        cls_in      = class_of(i_req.request_size);
        foreign     = {1'b0, i_req.address} >= 25'(ARENA_BYTES);
        span_in     = SPAN_IW'(i_req.address >> SPAN_SH);
        span_tagged = SU_W'(span_in) < r_spans_used;
        sum         = r_cur + r_osz;
        fits        = sum <= r_end;
        cur_link    = LINK_W'(r_cur[AW-1:4]) + LINK_W'(1);
        head_c      = r_heads[r_cls];
        base        = EW'(r_spans_used) << SPAN_SH;
        full        = (r_spans_used >= SU_W'(SPAN_COUNT)) ||
                      ((EW'(HEADER_BYTES) + r_osz) > EW'(SPAN_BYTES));
        span_we     = (r_state == S_ALOC) && (head_c == '0) && !full;
        link_ra     = SLOT_W'(head_c - LINK_W'(1));
        link_we     = 1'b0;
        link_wa     = SLOT_W'(r_prev - LINK_W'(1));
        link_wd     = fits ? cur_link : '0;
        unique case (r_state)
            S_FMT: begin
                link_we = (r_prev != '0);
            end
            S_FREE: begin
                link_we = 1'b1;
                link_wa = r_slot;
                link_wd = r_heads[r_tag_q];
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_q <= link_mem[link_ra];
        if (span_we) begin
            span_mem[SPAN_IW'(r_spans_used)] <= r_cls;
        end
        r_tag_q <= span_mem[span_in];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bound      <= 1'b0;
            r_spans_used <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_heads[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_bound <= i_cfg.shard_bound;
            end
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_out_addr <= '0;
                        r_out_cls  <= '0;
                        r_slot     <= i_req.address[AW-1:4];
                        r_cls      <= cls_in[3:0];
                        r_osz      <= obj_size(cls_in[3:0]);
                        priority if (!r_bound) begin
                            r_out_st    <= ST_FALLBACK;
                            r_out_valid <= 1'b1;
                        end else if (i_req.command == CMD_ALLOC) begin
                            if (cls_in[4]) begin
                                r_out_st    <= ST_FALLBACK;
                                r_out_valid <= 1'b1;
                            end else begin
                                r_state <= S_ALOC;
                            end
                        end else if (foreign) begin
                            r_out_st    <= ST_FALLBACK;
                            r_out_valid <= 1'b1;
                        end else if (!span_tagged) begin
                            r_out_st    <= ST_UNTAGGED;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end
                end
                S_ALOC: begin
                    priority if (head_c != '0) begin
                        r_state <= S_POP;
                    end else if (full) begin
                        r_out_st    <= ST_FULL;
                        r_out_cls   <= r_cls;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cur        <= base + EW'(HEADER_BYTES);
                        r_first      <= base + EW'(HEADER_BYTES);
                        r_end        <= base + EW'(SPAN_BYTES);
                        r_prev       <= '0;
                        r_spans_used <= r_spans_used + SU_W'(1);
                        r_state      <= S_FMT0;
                    end
                end
                S_POP: begin
                    r_heads[r_cls] <= r_link_q;
                    r_out_addr  <= 20'(AW'(head_c - LINK_W'(1)) << 4);
                    r_out_st    <= ST_OK;
                    r_out_cls   <= r_cls;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_FMT0: begin
                    r_cur   <= sum;
                    r_state <= S_FMT;
                end
                S_FMT: begin
                    if (fits) begin
                        if (r_prev == '0) begin
                            r_heads[r_cls] <= cur_link;
                        end
                        r_prev <= cur_link;
                        r_cur  <= sum;
                    end else begin
                        r_out_addr  <= 20'(r_first);
                        r_out_st    <= ST_OK;
                        r_out_cls   <= r_cls;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_FREE: begin
                    r_heads[r_tag_q] <= LINK_W'(r_slot) + LINK_W'(1);
                    r_out_st    <= ST_FREED;
                    r_out_cls   <= r_tag_q;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while busy");
    a_spans_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spans_used <= SU_W'(SPAN_COUNT))
        else $error("span count overflow");
    a_free_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status != ST_OK) |-> o_rsp.address_out == 20'd0)
        else $error("address on non-ok response");
`endif

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// testbench: random and directed checking of the slab size-class allocator
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ssca_pkg::*;

    typedef struct packed {
        logic [19:0] addr;
        logic [3:0]  cls;
        t_status     st;
    } t_alloc_rsp;

    localparam int unsigned OBJ_BYTES [16] = '{16, 32, 48, 64, 96, 128, 192, 256,
                                              384, 512, 768, 1024, 1536, 2048, 3072, 4096};

    logic i_clk;
    logic i_rst_n;

    ssca_cfg_if cfg ();
    ssca_req_if req ();
    ssca_rsp_if rsp ();

    slab_size_class_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // allocator model state
    logic        bound_q;
    logic [16:0] head_q [16];
    logic [16:0] link_q [SLOT_COUNT];
    logic [4:0]  span_tag_q [SPAN_COUNT];
    int unsigned spans_used_q;

    t_alloc_rsp  pending_rsp_q [$];
    logic [19:0] live_addr_q [$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic t_alloc_rsp model_alloc(input logic [15:0] size);
        t_alloc_rsp  r;
        int unsigned c, slot, base, osz, a, prev;
        r = '{addr: '0, cls: '0, st: ST_FALLBACK};
        c = 16;
        if (size <= MAX_SMALL_BYTES) begin
            for (int i = 15; i >= 0; i--) begin
                if (size <= OBJ_BYTES[i]) c = i;
            end
        end
        if (c >= 16) return r;
        r.cls = 4'(c);
        if (head_q[c] != 0) begin
            slot = head_q[c] - 1;
            head_q[c] = link_q[slot];
            r.addr = 20'(slot << 4);
            r.st = ST_OK;
            return r;
        end
        osz = OBJ_BYTES[c];
        if (spans_used_q >= SPAN_COUNT || HEADER_BYTES + osz > SPAN_BYTES) begin
            r.st = ST_FULL;
            return r;
        end
        base = spans_used_q * SPAN_BYTES;
        span_tag_q[spans_used_q] = {1'b1, 4'(c)};
        spans_used_q++;
        prev = 0;
        for (a = base + HEADER_BYTES + osz; a + osz <= base + SPAN_BYTES; a += osz) begin
            slot = a >> 4;
            link_q[slot] = '0;
            if (prev == 0) head_q[c] = 17'(slot + 1);
            else link_q[prev - 1] = 17'(slot + 1);
            prev = slot + 1;
        end
        r.addr = 20'(base + HEADER_BYTES);
        r.st = ST_OK;
        return r;
    endfunction

    function automatic t_alloc_rsp model_free(input logic [23:0] addr);
        t_alloc_rsp  r;
        int unsigned span, slot;
        r = '{addr: '0, cls: '0, st: ST_FALLBACK};
        if (addr >= ARENA_BYTES) return r;
        span = addr / SPAN_BYTES;
        if (span >= SPAN_COUNT || !span_tag_q[span][4]) begin
            r.st = ST_UNTAGGED;
            return r;
        end
        r.cls = span_tag_q[span][3:0];
        slot = addr >> 4;
        link_q[slot] = head_q[r.cls];
        head_q[r.cls] = 17'(slot + 1);
        r.st = ST_FREED;
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input t_cmd cmd, input logic [15:0] size,
                                input logic [23:0] addr);
        t_alloc_rsp r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.request_size <= size;
        req.address      <= addr;
        do @(posedge i_clk); while (!req.ready);
        if (!bound_q) r = '{addr: '0, cls: '0, st: ST_FALLBACK};
        else if (cmd == CMD_ALLOC) r = model_alloc(size);
        else r = model_free(addr);
        pending_rsp_q.push_back(r);
        if (cmd == CMD_ALLOC && r.st == ST_OK) live_addr_q.push_back(r.addr);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_bound(input logic value);
        wait_drained();
        cfg.valid       <= 1'b1;
        cfg.shard_bound <= value;
        do @(posedge i_clk); while (!cfg.ready);
        bound_q = value;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        int unsigned k, pick;
        logic [19:0] a;
        k = $urandom_range(99);
        if (k < 40 && live_addr_q.size() != 0) begin
            pick = $urandom_range(live_addr_q.size() - 1);
            a = live_addr_q[pick];
            live_addr_q.delete(pick);
            send_request(CMD_FREE, 16'($urandom), {4'h0, a});
        end else if (k < 80) begin
            send_request(CMD_ALLOC, 16'($urandom_range(0, MAX_SMALL_BYTES)), 24'($urandom));
        end else if (k < 88) begin
            send_request(CMD_ALLOC, 16'($urandom), 24'($urandom));
        end else if (k < 95) begin
            send_request(CMD_FREE, 16'($urandom), 24'($urandom_range(0, ARENA_BYTES - 1)));
        end else begin
            send_request(CMD_FREE, 16'($urandom), 24'($urandom));
        end
    endtask

    task automatic test_unbound();
        write_bound(1'b0);
        send_request(CMD_ALLOC, 16'd16, 24'd0);
        send_request(CMD_ALLOC, 16'hffff, 24'hffffff);
        send_request(CMD_FREE, 16'd0, 24'd64);
        send_request(CMD_FREE, 16'hffff, 24'hffffff);
    endtask

    task automatic test_directed();
        logic [19:0] first;
        write_bound(1'b1);
        send_request(CMD_ALLOC, 16'd0, 24'd0);
        first = live_addr_q[$];
        send_request(CMD_ALLOC, 16'd1, 24'd0);
        for (int i = 0; i < 16; i++) send_request(CMD_ALLOC, 16'(OBJ_BYTES[i]), 24'd0);
        send_request(CMD_ALLOC, 16'd4097, 24'd0);
        send_request(CMD_ALLOC, 16'hffff, 24'd0);
        send_request(CMD_FREE, 16'd0, 24'hffffff);
        send_request(CMD_FREE, 16'd0, 24'(ARENA_BYTES - 1));
        send_request(CMD_FREE, 16'd0, {4'h0, first} + 24'd7);
        send_request(CMD_FREE, 16'd0, 24'd8);
        send_request(CMD_FREE, 16'd0, {4'h0, first});
        send_request(CMD_ALLOC, 16'd5, 24'd0);
        send_request(CMD_ALLOC, 16'd5, 24'd0);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) send_random_request();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 300;
        repeat (40) send_random_request();
    endtask

    task automatic test_rebind();
        write_bound(1'b0);
        repeat (10) send_random_request();
        write_bound(1'b1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg.valid        = 1'b0;
        cfg.shard_bound  = 1'b0;
        req.valid        = 1'b0;
        req.command      = CMD_ALLOC;
        req.request_size = '0;
        req.address      = '0;
        rsp.ready        = 1'b0;
        bound_q          = 1'b0;
        spans_used_q     = 0;
        mismatches       = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_cycles      = 0;
        foreach (head_q[i]) head_q[i] = '0;
        foreach (span_tag_q[i]) span_tag_q[i] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_unbound();
        test_directed();
        test_random_phase(0, 0, 250);
        test_random_phase(84, 0, 250);
        test_backpressure();
        test_rebind();
        test_random_phase(0, 84, 250);
        test_random_phase(34, 34, 250);
        test_random_phase(0, 0, 100);

        wait_drained();
        repeat (1100) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            rsp.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response addr %h class %0d status %0d",
                             rsp.address_out, rsp.size_class, rsp.status);
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp.address_out !== want.addr || rsp.size_class !== want.cls ||
                    rsp.status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr %h class %0d status %0d, got %h %0d %0d",
                                 want.addr, want.cls, want.st,
                                 rsp.address_out, rsp.size_class, rsp.status);
                end
            end
        end
    end

endmodule
`default_nettype wire
